// ----- hdl/button_autorepeat_event_generator_unit_defines.svh -----
// Assertion macros used by the checker file of the autorepeat unit.
// No dependencies; include by bare file name.
`ifndef BUTTON_AUTOREPEAT_EVENT_GENERATOR_UNIT_DEFINES_SVH
`define BUTTON_AUTOREPEAT_EVENT_GENERATOR_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define BAREP_ASSERT_NOW(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("barep checker: invariant violated");

// When trig holds, conseq must hold in the next cycle.
`define BAREP_ASSERT_NEXT(label, clk, rst_n, trig, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (conseq)) \
		else $error("barep checker: sequence violated");

`endif

// ----- hdl/barep_pkg.sv -----
// Shared types and constants for the button autorepeat unit.
// No dependencies.
package barep_pkg;

	localparam int NUM_BUTTONS = 12;
	localparam int BTN_IN_W    = 12;
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int BIDX_OUT_W  = 4;

	localparam int BIDX_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int CNT_W   = $clog2(NUM_BUTTONS + 1);

	localparam int IN_TDATA_W  = ((TIME_W + BTN_IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((BIDX_OUT_W + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] RST_DELAY_MS  = CFG_W'(500);
	localparam logic [CFG_W-1:0] RST_PERIOD_MS = CFG_W'(100);

	typedef struct packed {
		logic [CFG_W-1:0] delay_ms;
		logic [CFG_W-1:0] period_ms;
	} cfg_t;

	// One classified poll, as it sits in the queue.
	typedef struct packed {
		logic [TIME_W-1:0]      now_ms;
		logic [NUM_BUTTONS-1:0] press_mask;
		logic [NUM_BUTTONS-1:0] hold_mask;
		logic [NUM_BUTTONS-1:0] rel_mask;
	} poll_t;

	typedef struct packed {
		logic [BIDX_W-1:0] idx;
		logic              press;
	} event_t;

endpackage

// ----- hdl/button_autorepeat_event_generator_unit.sv -----
// Top level of the button autorepeat event generator: config registers,
// front classifier, poll queue and back-end event scanner. Depends on barep_pkg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | one poll: now_ms, buttons_down
//  m_*     | out | m_tvalid/m_tready  | one event: button_index, is_press, last
//  cfg_*   | in  | cfg_we             | cfg_idx 0 first-repeat delay, 1 repeat period
//
// The back end scans the buttons of a poll in turn through the shared deadline
// add/compare, then closes out the poll.
// The front takes a poll per cycle while the two-entry queue has room.
// Output stalls hold the scanner only when a second event is ready to go.
// Reset clears the queue, the held-button history, config to 500/100.
module button_autorepeat_event_generator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] now_ms, [43:32] buttons_down, [47:44] zero
	input  logic [barep_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [3:0] button_index, [7:4] zero
	output logic [barep_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// [0] is_press
	output logic                               m_tuser,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [barep_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [barep_pkg::CFG_W-1:0]        cfg_data
);
	import barep_pkg::*;

	cfg_t  cfg_q;
	poll_t front_entry;
	poll_t head_entry;
	logic  q_push, q_pop, q_full, q_not_empty;

	// Config writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ms  <= RST_DELAY_MS;
			cfg_q.period_ms <= RST_PERIOD_MS;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DELAY_MS:  cfg_q.delay_ms  <= cfg_data;
				CFG_PERIOD_MS: cfg_q.period_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: classify press / hold / release per button.
	barep_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.s_tready (s_tready),
		.q_push   (q_push),
		.q_entry  (front_entry)
	);

	// Decouples poll intake from event emission.
	barep_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (front_entry),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rd_entry  (head_entry)
	);

	// Back: ascending scan, deadline bookkeeping, event beats.
	barep_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_not_empty),
		.q_entry  (head_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- hdl/barep_front.sv -----
// Front end: unpacks a poll beat and classifies each button against the last poll.
// Depends on barep_pkg.
module barep_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic [barep_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                              q_full,
	output logic                              s_tready,
	output logic                              q_push,
	output barep_pkg::poll_t                  q_entry
);
	import barep_pkg::*;

	logic [NUM_BUTTONS-1:0] prev_q;
	logic [NUM_BUTTONS-1:0] down;

	// A button's down flag is its bit in the current poll's buttons_down field.
	assign down     = NUM_BUTTONS'(s_tdata[TIME_W +: BTN_IN_W]);
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_entry.now_ms     = s_tdata[TIME_W-1:0];
		q_entry.press_mask = down & ~prev_q;
		q_entry.hold_mask  = down & prev_q;
		q_entry.rel_mask   = ~down & prev_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (q_push) begin
			prev_q <= down;
		end
	end

endmodule

// ----- hdl/barep_queue.sv -----
// Short FIFO of classified polls between front and back end.
// Depends on barep_pkg.
module barep_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  barep_pkg::poll_t wr_entry,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output barep_pkg::poll_t rd_entry
);
	import barep_pkg::*;

	poll_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/barep_back.sv -----
// Back end: scans buttons of the head poll one per cycle while no output
// stall holds it, keeps deadlines, holds one event back so the final one
// of a poll can carry tlast. Depends on barep_pkg.
module barep_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  barep_pkg::cfg_t                    cfg,
	input  logic                               q_valid,
	input  barep_pkg::poll_t                   q_entry,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [barep_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                               m_tuser,
	output logic                               m_tlast
);
	import barep_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] deadline_q [NUM_BUTTONS];
	logic              pend_valid_q;
	event_t            pend_q;
	logic              out_valid_q;
	event_t            out_q;
	logic              out_last_q;

	logic [BIDX_W-1:0] bi;
	logic [TIME_W-1:0] dl;
	logic              scan, is_new, is_rel, rpt, hit;
	logic              out_free, step, fin, load_out;

	always_comb begin
		scan   = q_valid && (cnt_q != CNT_W'(NUM_BUTTONS));
		bi     = cnt_q[BIDX_W-1:0];
		dl     = deadline_q[bi];
		is_new = q_entry.press_mask[bi];
		is_rel = q_entry.rel_mask[bi];
		rpt    = q_entry.hold_mask[bi] && (q_entry.now_ms > dl);
		hit    = scan && (is_new || is_rel || rpt);
		out_free = !out_valid_q || m_tready;
		// a new event displaces the pending one into the output register
		step     = scan && (!(hit && pend_valid_q) || out_free);
		fin      = q_valid && !scan && (!pend_valid_q || out_free);
		load_out = pend_valid_q && ((step && hit) || fin);
	end

	assign q_pop    = fin;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_q.idx);
	assign m_tuser  = out_q.press;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (step && scan) begin
			if (is_new) begin
				deadline_q[bi] <= q_entry.now_ms + TIME_W'(cfg.delay_ms);
			end else if (rpt) begin
				deadline_q[bi] <= dl + TIME_W'(cfg.period_ms);
			end
		end
		if (step && hit) begin
			pend_q.idx   <= bi;
			pend_q.press <= !is_rel;
		end
		if (load_out) begin
			out_q      <= pend_q;
			out_last_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin) begin
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
				if (hit) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/barep_checker.sv -----
// Port-level checker for the autorepeat unit, bound to the top level.
// Depends on barep_pkg and the defines header.
`include "button_autorepeat_event_generator_unit_defines.svh"

module barep_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [barep_pkg::IN_TDATA_W-1:0]   s_tdata,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [barep_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                               m_tuser,
	input logic                               m_tlast,
	input logic                               cfg_we,
	input logic [barep_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input logic [barep_pkg::CFG_W-1:0]        cfg_data
);
	import barep_pkg::*;

	logic                  run_q;
	logic [BIDX_OUT_W-1:0] last_idx_q;
	logic                  out_beat;
	logic                  unused_ok;

	assign out_beat  = m_tvalid && m_tready;
	assign unused_ok = s_tvalid ^ s_tready ^ (^s_tdata) ^ cfg_we ^ (^cfg_idx) ^ (^cfg_data);

	// Track whether we are inside a poll's run of events.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			last_idx_q <= '0;
		end else if (out_beat) begin
			run_q      <= !m_tlast;
			last_idx_q <= m_tdata[BIDX_OUT_W-1:0];
		end
	end

	`BAREP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`BAREP_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`BAREP_ASSERT_NOW(a_idx_range, clk, arst_n, !m_tvalid || (m_tdata[BIDX_OUT_W-1:0] < BIDX_OUT_W'(NUM_BUTTONS)))
	`BAREP_ASSERT_NOW(a_idx_ascend, clk, arst_n, !(m_tvalid && run_q) || (m_tdata[BIDX_OUT_W-1:0] > last_idx_q))

endmodule

bind button_autorepeat_event_generator_unit barep_checker u_barep_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast),
	.cfg_we   (cfg_we),
	.cfg_idx  (cfg_idx),
	.cfg_data (cfg_data)
);
